// ===== hw/rtl/multisynth_divider_encoder_defines.svh =====
// Assertion macros used by the checker module of the divider encoder.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef MULTISYNTH_DIVIDER_ENCODER_DEFINES_SVH
`define MULTISYNTH_DIVIDER_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mde_pkg.sv =====
`timescale 1ns / 1ps

package mde_pkg;

    // Field widths.
    localparam int INT_W   = 10;
    localparam int DEN_W   = 20;
    localparam int SCALE_W = 7;
    localparam int Q_W     = DEN_W + SCALE_W;
    localparam int SUM_W   = Q_W + 1;
    localparam int P1_W    = 18;

    // One quotient bit per divider stage.
    localparam int DIV_STEPS = Q_W;

    // Request types.
    localparam logic REQ_PLL = 1'b0;
    localparam logic REQ_OUT = 1'b1;

    // Range limits of the integer part.
    localparam logic [INT_W-1:0] PLL_A_MIN = 10'd15;
    localparam logic [INT_W-1:0] PLL_A_MAX = 10'd90;
    localparam logic [INT_W-1:0] OUT_A_MIN = 10'd8;
    localparam logic [INT_W-1:0] OUT_A_MAX = 10'd900;

    localparam logic [2:0] CLK_IDX_MAX    = 3'd5;
    localparam logic [2:0] TARGET_MS_BASE = 3'd2;
    localparam logic [2:0] TARGET_NONE    = 3'd0;

    // P1 = sum - 512 must lie in 0 .. 2^18-1.
    localparam logic [SUM_W-1:0] P1_BASE = SUM_W'(512);
    localparam logic [SUM_W-1:0] P1_TOP  = SUM_W'(512 + (1 << P1_W) - 1);

    typedef struct packed {
        logic        req_type;
        logic        pll_select;
        logic [2:0]  clock_index;
        logic [9:0]  int_part;
        logic [19:0] numerator;
        logic [19:0] denominator;
        logic [7:0]  r_divider;
        logic [7:0]  phase;
    } t_mde_in;

    typedef struct packed {
        logic       ok;
        logic [2:0] target;
        logic [7:0] phase_out;
        logic [7:0] param_byte0;
        logic [7:0] param_byte1;
        logic [7:0] param_byte2;
        logic [7:0] param_byte3;
        logic [7:0] param_byte4;
        logic [7:0] param_byte5;
        logic [7:0] param_byte6;
        logic [7:0] param_byte7;
    } t_mde_out;

    // Item state carried through the divider stages. dq holds the dividend bits still
    // to be consumed in its upper part and the quotient bits built so far in its lower part.
    typedef struct packed {
        logic             ok;
        logic [2:0]       target;
        logic [7:0]       phase_out;
        logic [2:0]       r_code;
        logic [INT_W-1:0] int_part;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   dq;
    } t_div_stage;

endpackage

// ===== hw/rtl/mde_div_pipe.sv =====
`timescale 1ns / 1ps

module mde_div_pipe
    import mde_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_div_stage i_stg,
    output logic       o_valid,
    output t_div_stage o_stg
);

    t_div_stage r_stg [DIV_STEPS];
    logic       r_vld [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        t_div_stage     s_prev;
        t_div_stage     n_stg;
        logic           v_prev;
        logic [DEN_W:0] trial;
        logic [DEN_W+1:0] diff;
        logic           ge;

        if (k == 0) begin : g_first
            assign s_prev = i_stg;
            assign v_prev = i_valid;
        end else begin : g_rest
            assign s_prev = r_stg[k-1];
            assign v_prev = r_vld[k-1];
        end

        // Restoring step: bring down the next dividend bit and try to subtract.
        assign trial = {s_prev.rem, s_prev.dq[Q_W-1]};
        assign diff  = {1'b0, trial} - {2'b00, s_prev.den};
        assign ge    = ~diff[DEN_W+1];

        always_comb begin
            n_stg     = s_prev;
            n_stg.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_stg.dq  = {s_prev.dq[Q_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_prev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[k] <= n_stg;
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS-1];
    assign o_stg   = r_stg[DIV_STEPS-1];

endmodule

// ===== hw/rtl/multisynth_divider_encoder.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_stall  i_data (t_mde_in)
// result    out        o_valid / i_stall  o_data (t_mde_out)
//
// One request is taken in every cycle in which o_stall is low; each gives one result.
// Each request passes through the divider, one quotient bit per stage over 27 stages,
// plus a decode stage in front and the packing stage that forms the output register.
// Reset is synchronous and active low; it clears the valid bits only.
// A stalled result freezes the whole pipeline, so o_stall follows i_stall while a result waits.

module multisynth_divider_encoder
    import mde_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_mde_in  i_data,
    output logic     o_stall,
    output logic     o_valid,
    output t_mde_out o_data,
    input  logic     i_stall
);

    // The pipeline advances whenever the output register is empty or its transfer completes.
    logic en;

    t_div_stage n_front;
    t_div_stage r_front;
    logic       r_front_vld;

    logic       div_vld;
    t_div_stage div_stg;

    t_mde_out   n_out;
    t_mde_out   r_out;
    logic       r_out_valid;

    logic [2:0] rdiv_code;
    logic       a_ok;

    assign en      = ~r_out_valid | ~i_stall;
    assign o_stall = ~en;

    // The R divider must be a single power of two; its code is the position of that bit.
    always_comb begin
        rdiv_code = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (i_data.r_divider[k]) begin
                rdiv_code = 3'(k);
            end
        end
    end

    // Decode stage: every check that does not need the quotient is done here,
    // and the numerator is scaled by 128 to form the dividend.
    always_comb begin
        n_front           = '0;
        n_front.int_part  = i_data.int_part;
        n_front.den       = i_data.denominator;
        n_front.rem       = '0;
        n_front.dq        = {i_data.numerator, {SCALE_W{1'b0}}};
        a_ok              = 1'b0;
        if (i_data.req_type == REQ_PLL) begin
            n_front.target    = {2'b00, i_data.pll_select};
            n_front.phase_out = '0;
            n_front.r_code    = '0;
            a_ok = (i_data.int_part >= PLL_A_MIN) && (i_data.int_part <= PLL_A_MAX);
            n_front.ok = a_ok;
        end else begin
            n_front.phase_out = i_data.phase;
            n_front.r_code    = rdiv_code;
            a_ok = (i_data.int_part >= OUT_A_MIN) && (i_data.int_part <= OUT_A_MAX);
            if (i_data.clock_index <= CLK_IDX_MAX) begin
                n_front.target = i_data.clock_index + TARGET_MS_BASE;
                n_front.ok     = a_ok && $onehot(i_data.r_divider);
            end else begin
                n_front.target = TARGET_NONE;
                n_front.ok     = 1'b0;
            end
        end
        // A zero denominator can never give a valid ratio.
        if (i_data.denominator == '0) begin
            n_front.ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_vld <= 1'b0;
        end else if (en) begin
            r_front_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_front <= n_front;
        end
    end

    mde_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_front_vld),
        .i_stg   (r_front),
        .o_valid (div_vld),
        .o_stg   (div_stg)
    );

    // Packing stage: P1 from the quotient and the integer part, P2 is the remainder,
    // P3 the denominator. A failed request shows zero in all eight parameter bytes.
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] p1_full;
    logic [P1_W-1:0]  p1;
    logic [DEN_W-1:0] p2;
    logic [DEN_W-1:0] p3;
    logic             ok;

    assign sum     = SUM_W'({div_stg.int_part, {SCALE_W{1'b0}}}) + SUM_W'(div_stg.dq);
    assign p1_full = sum - P1_BASE;
    assign p1      = p1_full[P1_W-1:0];
    assign p2      = div_stg.rem;
    assign p3      = div_stg.den;
    assign ok      = div_stg.ok && (sum >= P1_BASE) && (sum <= P1_TOP);

    always_comb begin
        n_out           = '0;
        n_out.ok        = ok;
        n_out.target    = div_stg.target;
        n_out.phase_out = div_stg.phase_out;
        if (ok) begin
            n_out.param_byte0 = p3[15:8];
            n_out.param_byte1 = p3[7:0];
            n_out.param_byte2 = {1'b0, div_stg.r_code, 2'b00, p1[17:16]};
            n_out.param_byte3 = p1[15:8];
            n_out.param_byte4 = p1[7:0];
            n_out.param_byte5 = {p3[19:16], p2[19:16]};
            n_out.param_byte6 = p2[15:8];
            n_out.param_byte7 = p2[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== hw/rtl/mde_checker.sv =====
`timescale 1ns / 1ps
`include "multisynth_divider_encoder_defines.svh"

module mde_checker
    import mde_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input t_mde_in  i_data,
    input logic     o_stall,
    input logic     o_valid,
    input t_mde_out o_data,
    input logic     i_stall
);

    logic [19:0] p2_seen;
    logic [19:0] p3_seen;
    logic        bytes_zero;

    assign p2_seen = {o_data.param_byte5[3:0], o_data.param_byte6, o_data.param_byte7};
    assign p3_seen = {o_data.param_byte5[7:4], o_data.param_byte0, o_data.param_byte1};
    assign bytes_zero = (o_data.param_byte0 == '0) && (o_data.param_byte1 == '0)
                     && (o_data.param_byte2 == '0) && (o_data.param_byte3 == '0)
                     && (o_data.param_byte4 == '0) && (o_data.param_byte5 == '0)
                     && (o_data.param_byte6 == '0) && (o_data.param_byte7 == '0);

    `MDE_ASSERT_SAME(a_fail_zero, o_valid && !o_data.ok, bytes_zero, "failed result carries parameter bytes")
    `MDE_ASSERT_SAME(a_rem_below_den, o_valid && o_data.ok, p2_seen < p3_seen, "P2 not below P3")
    `MDE_ASSERT_SAME(a_pll_no_r, o_valid && o_data.ok && (o_data.target < TARGET_MS_BASE), (o_data.phase_out == '0) && (o_data.param_byte2[6:4] == '0), "PLL result carries phase or R code")
    `MDE_ASSERT_SAME(a_byte2_spare, o_valid, (o_data.param_byte2[7] == 1'b0) && (o_data.param_byte2[3:2] == 2'b00), "spare bits of byte 2 set")
    `MDE_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data), "stalled result changed")

endmodule

bind multisynth_divider_encoder mde_checker u_mde_checker (.*);

// ===== verif/mde_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the divider encoder, works out the parameter set that
// each accepted request should give and compares it with the result transfers in order.
module mde_tb_checker
    import mde_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  logic     i_req_stall,
    input  t_mde_in  i_req_data,
    input  logic     i_res_valid,
    input  logic     i_res_stall,
    input  t_mde_out i_res_data,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_result_count,
    output int       o_ok_count
);

    localparam int PLL_INT_LO     = 15;
    localparam int PLL_INT_HI     = 90;
    localparam int OUT_INT_LO     = 8;
    localparam int OUT_INT_HI     = 900;
    localparam int CLK_LAST       = 5;
    localparam int MS_TARGET_BASE = 2;
    localparam int NO_TARGET      = 0;
    localparam int P1_OFFSET      = 512;
    localparam int P1_MAX         = (1 << 18) - 1;

    t_mde_out expected_params[$];
    t_mde_out want;
    int       fail_total   = 0;
    int       result_total = 0;
    int       ok_total     = 0;
    int       pending      = 0;

    assign o_fail_count   = fail_total;
    assign o_pending      = pending;
    assign o_result_count = result_total;
    assign o_ok_count     = ok_total;

    // Works out the result of one divider request a + b/c.
    function automatic t_mde_out encode_request(t_mde_in req);
        t_mde_out    res;
        logic        ok;
        logic        r_ok;
        logic [2:0]  rcode;
        logic [26:0] scaled;
        logic [26:0] quot;
        logic [19:0] rem;
        logic [27:0] sum;
        logic [17:0] p1;
        int          k;
        res    = '0;
        ok     = 1'b1;
        r_ok   = 1'b0;
        rcode  = '0;
        quot   = '0;
        rem    = '0;
        p1     = '0;
        scaled = {req.numerator, 7'd0};
        if (req.req_type == REQ_PLL) begin
            res.target = {2'b00, req.pll_select};
            if (req.int_part < PLL_INT_LO || req.int_part > PLL_INT_HI) ok = 1'b0;
        end else begin
            res.phase_out = req.phase;
            if (req.clock_index <= CLK_LAST) begin
                res.target = 3'(req.clock_index + MS_TARGET_BASE);
            end else begin
                res.target = 3'(NO_TARGET);
                ok = 1'b0;
            end
            if (req.int_part < OUT_INT_LO || req.int_part > OUT_INT_HI) ok = 1'b0;
            for (k = 0; k < 8; k++) begin
                if (req.r_divider == 8'(1 << k)) begin
                    rcode = 3'(k);
                    r_ok  = 1'b1;
                end
            end
            if (!r_ok) ok = 1'b0;
        end
        // P2 and P3 cannot exceed 20 bits here, as P2 < c and c is itself 20 bits wide.
        if (req.denominator == '0) begin
            ok = 1'b0;
        end else begin
            quot = scaled / 27'(req.denominator);
            rem  = 20'(scaled % 27'(req.denominator));
            sum  = {11'd0, req.int_part, 7'd0} + {1'b0, quot};
            if (sum < P1_OFFSET) ok = 1'b0;
            else if (sum - P1_OFFSET > P1_MAX) ok = 1'b0;
            else p1 = 18'(sum - P1_OFFSET);
        end
        res.ok = ok;
        if (ok) begin
            res.param_byte0 = req.denominator[15:8];
            res.param_byte1 = req.denominator[7:0];
            res.param_byte2 = {1'b0, rcode, 2'b00, p1[17:16]};
            res.param_byte3 = p1[15:8];
            res.param_byte4 = p1[7:0];
            res.param_byte5 = {req.denominator[19:16], rem[19:16]};
            res.param_byte6 = rem[15:8];
            res.param_byte7 = rem[7:0];
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (got_val !== exp_val) begin
            fail_total++;
            $display("%0t: %s expected %02h, got %02h", $time, name, exp_val, got_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res_valid && !i_res_stall) begin
                result_total++;
                if (expected_params.size() == 0) begin
                    fail_total++;
                    $display("%0t: result transfer expected none, got %h",
                             $time, i_res_data);
                end else begin
                    want = expected_params.pop_front();
                    if (want.ok) ok_total++;
                    check_field("ok", 8'(want.ok), 8'(i_res_data.ok));
                    check_field("target", 8'(want.target), 8'(i_res_data.target));
                    check_field("phase_out", want.phase_out, i_res_data.phase_out);
                    check_field("param_byte0", want.param_byte0, i_res_data.param_byte0);
                    check_field("param_byte1", want.param_byte1, i_res_data.param_byte1);
                    check_field("param_byte2", want.param_byte2, i_res_data.param_byte2);
                    check_field("param_byte3", want.param_byte3, i_res_data.param_byte3);
                    check_field("param_byte4", want.param_byte4, i_res_data.param_byte4);
                    check_field("param_byte5", want.param_byte5, i_res_data.param_byte5);
                    check_field("param_byte6", want.param_byte6, i_res_data.param_byte6);
                    check_field("param_byte7", want.param_byte7, i_res_data.param_byte7);
                end
            end
            if (i_req_valid && !i_req_stall)
                expected_params.push_back(encode_request(i_req_data));
        end
        pending = expected_params.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Top of the divider encoder testbench. It makes the request traffic, drives the
// result stall and gives the verdict; all prediction and comparison live in the
// checker instantiated beside the block.
module tb_top
    import mde_pkg::*;
();

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int N_RANDOM       = 1280;
    // The result side holds off for this many cycles once, far longer than the
    // 29-stage pipeline, so that the block fills up and stalls its request side.
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 5000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    t_mde_in  i_data;
    logic     o_stall;
    logic     o_valid;
    t_mde_out o_data;
    logic     i_stall;

    int fail_count;
    int pending_count;
    int result_count;
    int ok_count;
    int pll_sent      = 0;
    int out_sent      = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 26;
    int recv_idle_pct = 66;
    bit hold_request  = 1'b0;
    bit hold_done     = 1'b0;

    multisynth_divider_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    mde_tb_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_req_data     (i_data),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_res_data     (o_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_result_count (result_count),
        .o_ok_count     (ok_count)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Builds one request from plain numbers; the casts keep each field at its width.
    function automatic t_mde_in make_request(logic rt, logic ps, int ci, int a, int b, int c,
                                             int r, int ph);
        t_mde_in req;
        req.req_type    = rt;
        req.pll_select  = ps;
        req.clock_index = 3'(ci);
        req.int_part    = 10'(a);
        req.numerator   = 20'(b);
        req.denominator = 20'(c);
        req.r_divider   = 8'(r);
        req.phase       = 8'(ph);
        return req;
    endfunction

    // Most random requests are well formed, so that the divider and the packing are
    // exercised with ok set. About one in ten of those has one check deliberately
    // broken, and a further share is raw noise across every bit of the payload.
    function automatic t_mde_in random_request();
        t_mde_in     req;
        logic [95:0] raw;
        int          w;
        if ($urandom_range(99) < 15) begin
            raw = {$urandom, $urandom, $urandom};
            req = raw[$bits(t_mde_in)-1:0];
        end else begin
            req.req_type    = $urandom_range(1) ? REQ_OUT : REQ_PLL;
            req.pll_select  = 1'($urandom_range(1));
            req.clock_index = 3'($urandom_range(5));
            req.phase       = 8'($urandom_range(255));
            if (req.req_type == REQ_PLL) begin
                req.int_part  = 10'($urandom_range(90, 15));
                req.r_divider = 8'($urandom_range(255));
            end else begin
                req.int_part  = 10'($urandom_range(900, 8));
                req.r_divider = 8'(1 << $urandom_range(7));
            end
            // Spread the denominator over every magnitude rather than only large values.
            w = $urandom_range(20, 1);
            req.denominator = 20'($urandom_range((1 << w) - 1, 1));
            case ($urandom_range(3))
                0: req.numerator = 20'($urandom_range(req.denominator - 1, 0));
                1: req.numerator = 20'($urandom);
                2: req.numerator = '0;
                default: req.numerator = req.denominator - 20'd1;
            endcase
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: req.denominator = '0;
                    1: req.int_part = 10'($urandom_range(1023));
                    2: req.clock_index = 3'($urandom_range(7, 6));
                    default: req.r_divider = 8'($urandom_range(255));
                endcase
            end
        end
        return req;
    endfunction

    // Offers one request, idling beforehand at the current sender rate, and returns
    // at the edge where the transfer takes place. Valid stays high into the next
    // request when no idle cycle follows, so it is never lowered and raised in one step.
    task automatic send_request(input t_mde_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        if (req.req_type == REQ_PLL) pll_sent++;
        else out_sent++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Result side. It stalls at random at the current receiver rate, and once, when
    // asked, holds off for a long stretch counted here while requests keep coming.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // The watchdog counts cycles in which neither channel completes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("multisynth_divider_encoder: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: the range edges of both request types, every rejection
        // reason, the fields that each type ignores and the limits of P1.
        send_request(make_request(REQ_PLL, 0, 0, 15, 0, 1, 0, 0));
        send_request(make_request(REQ_PLL, 1, 0, 90, 20'hFFFFE, 20'hFFFFF, 0, 0));
        send_request(make_request(REQ_PLL, 0, 0, 14, 5, 7, 0, 0));
        send_request(make_request(REQ_PLL, 1, 0, 91, 5, 7, 0, 0));
        send_request(make_request(REQ_PLL, 0, 0, 50, 1, 0, 0, 0));
        send_request(make_request(REQ_PLL, 1, 7, 40, 3, 9, 8'hFF, 8'hFF));
        send_request(make_request(REQ_PLL, 0, 0, 36, 20'hABCDE, 20'hFFFFD, 0, 0));
        send_request(make_request(REQ_PLL, 0, 0, 2, 0, 5, 0, 0));
        send_request(make_request(REQ_OUT, 0, 0, 8, 0, 1, 1, 0));
        send_request(make_request(REQ_OUT, 1, 5, 900, 20'hFFFFF, 20'hFFFFF, 128, 8'hFF));
        send_request(make_request(REQ_OUT, 0, 6, 100, 1, 3, 4, 8'h5A));
        send_request(make_request(REQ_OUT, 0, 7, 100, 1, 3, 4, 8'hA5));
        send_request(make_request(REQ_OUT, 0, 1, 7, 1, 3, 8, 8'h11));
        send_request(make_request(REQ_OUT, 0, 2, 901, 1, 3, 8, 8'h22));
        send_request(make_request(REQ_OUT, 0, 3, 200, 1, 3, 0, 8'h33));
        send_request(make_request(REQ_OUT, 0, 4, 200, 1, 3, 3, 8'h44));
        send_request(make_request(REQ_OUT, 1, 5, 200, 1, 3, 255, 8'h55));
        send_request(make_request(REQ_OUT, 0, 0, 300, 9, 0, 16, 8'h3C));
        // P1 exactly at its 18-bit ceiling, then one step above it.
        send_request(make_request(REQ_OUT, 0, 2, 900, 147455, 128, 2, 1));
        send_request(make_request(REQ_OUT, 0, 3, 900, 147456, 128, 2, 1));
        send_request(make_request(REQ_OUT, 0, 4, 900, 20'hFFFFF, 1, 64, 0));
        send_request(make_request(REQ_OUT, 0, 1, 3, 0, 1, 1, 0));
        send_request('1);
        send_request('0);

        // Random requests in three idling mixes; the long hold-off on the result side
        // starts with the last mix, where the sender offers a request every cycle.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 66;
                recv_idle_pct = 26;
            end
            if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request  = 1'b1;
            end
            send_request(random_request());
        end
        i_valid <= 1'b0;

        // Let the checker record the last transfer, drain the pipeline, then give
        // any stray result time to show itself.
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d PLL and %0d output divider requests; %0d results came back, %0d valid.",
                 pll_sent, out_sent, result_count, ok_count);
        $display("Traffic ran sender-idle, receiver-idle and back-to-back, with one long hold-off.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("multisynth_divider_encoder: match");
        end else begin
            $display("multisynth_divider_encoder: mismatch");
        end
        $finish;
    end

endmodule
